/* src/sfuc_pkg.sv */
// Package: constants, widths and helpers for the sector fiducial cut.
package sfuc_pkg;

    localparam int COORD_FRAC_BITS = 6;

    localparam int IN_W   = 17;
    localparam int CFG_W  = 18;
    localparam int OUT_W  = 18;
    localparam int SEC_W  = 3;
    localparam int NCFG   = 4;
    localparam int ADDR_W = 4;

    localparam int PX_W   = 34;
    localparam int SQ_W   = 35;
    localparam int T_W    = 36;
    localparam int A_W    = 38;
    localparam int P_W    = 58;
    localparam int R_W    = 26;
    localparam int W16_W  = 42;
    localparam int WP_W   = 60;
    localparam int WR_W   = 28;

    localparam logic [SEC_W-1:0] SECTOR_0 = 3'd0;
    localparam logic [SEC_W-1:0] SECTOR_1 = 3'd1;
    localparam logic [SEC_W-1:0] SECTOR_2 = 3'd2;
    localparam logic [SEC_W-1:0] SECTOR_3 = 3'd3;
    localparam logic [SEC_W-1:0] SECTOR_4 = 3'd4;
    localparam logic [SEC_W-1:0] SECTOR_5 = 3'd5;

    localparam logic [1:0] REG_U_MIN = 2'd0;
    localparam logic [1:0] REG_U_MAX = 2'd1;
    localparam logic [1:0] REG_V_MAX = 2'd2;
    localparam logic [1:0] REG_W_MAX = 2'd3;

    localparam logic signed [CFG_W-1:0] U_MIN_RST = 18'sd4480;
    localparam logic signed [CFG_W-1:0] U_MAX_RST = 18'sd25920;
    localparam logic signed [CFG_W-1:0] V_MAX_RST = 18'sd23168;
    localparam logic signed [CFG_W-1:0] W_MAX_RST = 18'sd25280;

    // Q16 rotation and plane coefficients
    localparam logic signed [16:0] C_CYX_HALF = 17'sd29698;
    localparam logic signed [16:0] C_CYY      = 17'sd51438;
    localparam logic signed [16:0] C_SIN_THE  = 17'sd27697;
    localparam logic signed [16:0] C_SIN_PHI  = 17'sd56756;
    localparam logic signed [17:0] C_RSIN     = 18'sd73626;
    localparam logic signed [16:0] C_RTG      = 17'sd33552;
    localparam logic signed [17:0] C_RCOS2    = 18'sd71905;

    localparam longint YLOW_Q16  = -64'sd11991384;
    localparam longint YHI_Q16   = 64'sd12448956;
    localparam longint SCALE     = longint'(1) <<< COORD_FRAC_BITS;
    localparam logic signed [A_W-1:0] YLO_S  = A_W'(YLOW_Q16 * SCALE);
    localparam logic signed [A_W-1:0] PLANE_S = A_W'(2 * YHI_Q16 * SCALE - YLOW_Q16 * SCALE);

    localparam logic signed [P_W-1:0]   HALF32_P = P_W'(64'sd1 <<< 31);
    localparam logic signed [P_W-1:0]   HALF16_P = P_W'(64'sd1 <<< 15);
    localparam logic signed [WP_W-1:0]  HALF32_W = WP_W'(64'sd1 <<< 31);

    localparam logic signed [WR_W-1:0] OUT_MAX = WR_W'(131071);
    localparam logic signed [WR_W-1:0] OUT_MIN = -WR_W'(131072);

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WR_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX)
            r = OUT_W'(OUT_MAX);
        else if (v < OUT_MIN)
            r = OUT_W'(OUT_MIN);
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

/* src/sector_fiducial_uvw_cut.sv */
// Top level: sector finder, sector-frame rotation and u/v/w fiducial cut pipeline.
//
//  channel  | dir | handshake              | payload
//  s_*      | in  | s_tvalid / s_tready    | tdata: hit_x, hit_y, hit_z
//  m_*      | out | m_tvalid / m_tready    | tdata: coord_u/v/w; tuser: inside_res, sector
//  apb      | in  | psel, penable, pready  | u_min, u_max, v_max, w_max at 0x0, 0x4, 0x8, 0xC
//
// Nine register stages, one hit per cycle unless m_tready stalls the pipeline.
// The stage depth is set by the 38x18 and 42x18 constant multipliers of the plane mapping.
// rst_n clears the stage valid bits and loads the register defaults.
// A stall on m_tready holds every stage; s_tready drops only while the output is full and held.
module sector_fiducial_uvw_cut
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // hit_x[16:0], hit_y[33:17], hit_z[50:34], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // coord_u[17:0], coord_v[35:18], coord_w[53:36], zero pad
    output logic [3:0]  m_tuser,   // inside_res[0], sector[3:1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [sfuc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic en;
    logic [8:0] vld_reg;

    logic signed [sfuc_pkg::CFG_W-1:0] cfg_reg [sfuc_pkg::NCFG];
    logic [1:0] cfg_idx;

    // stage 1
    logic signed [sfuc_pkg::IN_W-1:0] x1_reg, y1_reg, z1_reg;
    // stage 2
    logic signed [sfuc_pkg::IN_W-1:0] x2_reg, y2_reg;
    logic signed [sfuc_pkg::PX_W-1:0] xsq2_reg, ysq2_reg, px2_reg, py2_reg, pz2_reg, ps2_reg;
    // stage 3
    logic [sfuc_pkg::SEC_W-1:0] sec3_reg, sec3_next;
    logic signed [sfuc_pkg::IN_W-1:0] y3_reg;
    logic signed [sfuc_pkg::PX_W-1:0] px3_reg, py3_reg, pz3_reg, ps3_reg;
    logic signed [sfuc_pkg::SQ_W-1:0] xsq_e, ysq3_e;
    // stage 4
    logic [sfuc_pkg::SEC_W-1:0] sec4_reg;
    logic signed [sfuc_pkg::T_W-1:0] yi4_reg, xi4_reg, yi4_next, xi4_next;
    logic signed [sfuc_pkg::T_W-1:0] cyx_t, cyy_t, cos_t, sin_t, pxe, pye, pse, ye;
    // stage 5
    logic [sfuc_pkg::SEC_W-1:0] sec5_reg;
    logic signed [sfuc_pkg::A_W-1:0] a5_reg, b5_reg;
    logic signed [sfuc_pkg::P_W-1:0] xs5_reg;
    // stage 6
    logic [sfuc_pkg::SEC_W-1:0] sec6_reg;
    logic signed [sfuc_pkg::P_W-1:0] up6_reg, p6_reg, xs6_reg;
    // stage 7
    logic [sfuc_pkg::SEC_W-1:0] sec7_reg;
    logic signed [sfuc_pkg::R_W-1:0] u7_reg, v7_reg;
    logic signed [sfuc_pkg::W16_W-1:0] w7_reg;
    logic signed [sfuc_pkg::P_W-1:0] usum, vsum, wsum;
    // stage 8
    logic [sfuc_pkg::SEC_W-1:0] sec8_reg;
    logic signed [sfuc_pkg::R_W-1:0] u8_reg, v8_reg;
    logic signed [sfuc_pkg::WP_W-1:0] wp8_reg;
    // stage 9 (output)
    logic signed [sfuc_pkg::WP_W-1:0] wround;
    logic signed [sfuc_pkg::WR_W-1:0] w9, u9, v9;
    logic pass_next;
    logic [sfuc_pkg::SEC_W-1:0] sec9_reg;
    logic inside9_reg;
    logic signed [sfuc_pkg::OUT_W-1:0] u9_reg, v9_reg, w9_reg;

    assign en       = !vld_reg[8] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[8];
    assign m_tdata  = {2'b00, w9_reg, v9_reg, u9_reg};
    assign m_tuser  = {sec9_reg, inside9_reg};

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign prdata  = {{(32-sfuc_pkg::CFG_W){1'b0}}, cfg_reg[cfg_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[sfuc_pkg::REG_U_MIN] <= sfuc_pkg::U_MIN_RST;
            cfg_reg[sfuc_pkg::REG_U_MAX] <= sfuc_pkg::U_MAX_RST;
            cfg_reg[sfuc_pkg::REG_V_MAX] <= sfuc_pkg::V_MAX_RST;
            cfg_reg[sfuc_pkg::REG_W_MAX] <= sfuc_pkg::W_MAX_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            cfg_reg[cfg_idx] <= pwdata[sfuc_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[7:0], s_tvalid};
    end

    // sector decision from squares
    always_comb
    begin
        xsq_e  = sfuc_pkg::SQ_W'(xsq2_reg);
        ysq3_e = (sfuc_pkg::SQ_W'(ysq2_reg) <<< 1) + sfuc_pkg::SQ_W'(ysq2_reg);
        if (y2_reg == '0)
            sec3_next = (x2_reg < 0) ? sfuc_pkg::SECTOR_3 : sfuc_pkg::SECTOR_0;
        else if (y2_reg > 0)
        begin
            if (x2_reg > 0)
                sec3_next = (ysq3_e > xsq_e) ? sfuc_pkg::SECTOR_1 : sfuc_pkg::SECTOR_0;
            else if (x2_reg == '0)
                sec3_next = sfuc_pkg::SECTOR_2;
            else
                sec3_next = (xsq_e > ysq3_e) ? sfuc_pkg::SECTOR_3 : sfuc_pkg::SECTOR_2;
        end
        else
        begin
            if (x2_reg < 0)
                sec3_next = (ysq3_e > xsq_e) ? sfuc_pkg::SECTOR_4 : sfuc_pkg::SECTOR_3;
            else if (x2_reg == '0)
                sec3_next = sfuc_pkg::SECTOR_5;
            else
                sec3_next = (xsq_e > ysq3_e) ? sfuc_pkg::SECTOR_0 : sfuc_pkg::SECTOR_5;
        end
    end

    // sector rotation and tilt
    always_comb
    begin
        pxe = sfuc_pkg::T_W'(px3_reg);
        pye = sfuc_pkg::T_W'(py3_reg);
        pse = sfuc_pkg::T_W'(ps3_reg);
        ye  = sfuc_pkg::T_W'(y3_reg);
        unique case (sec3_reg)
            sfuc_pkg::SECTOR_1:
            begin
                cyx_t = pxe;            cyy_t = pye;
                cos_t = ye <<< 15;      sin_t = pse;
            end
            sfuc_pkg::SECTOR_2:
            begin
                cyx_t = -pxe;           cyy_t = pye;
                cos_t = -(ye <<< 15);   sin_t = pse;
            end
            sfuc_pkg::SECTOR_3:
            begin
                cyx_t = -(pxe <<< 1);   cyy_t = '0;
                cos_t = -(ye <<< 16);   sin_t = '0;
            end
            sfuc_pkg::SECTOR_4:
            begin
                cyx_t = -pxe;           cyy_t = -pye;
                cos_t = -(ye <<< 15);   sin_t = -pse;
            end
            sfuc_pkg::SECTOR_5:
            begin
                cyx_t = pxe;            cyy_t = -pye;
                cos_t = ye <<< 15;      sin_t = -pse;
            end
            default:
            begin
                cyx_t = pxe <<< 1;      cyy_t = '0;
                cos_t = ye <<< 16;      sin_t = '0;
            end
        endcase
        yi4_next = cyx_t + cyy_t - sfuc_pkg::T_W'(pz3_reg);
        xi4_next = cos_t - sin_t;
    end

    // rounding of the plane products
    always_comb
    begin
        usum = up6_reg + sfuc_pkg::HALF32_P;
        vsum = p6_reg - xs6_reg + sfuc_pkg::HALF32_P;
        wsum = p6_reg + xs6_reg + sfuc_pkg::HALF16_P;
    end

    // final rounding, cut and saturation
    always_comb
    begin
        wround    = wp8_reg + sfuc_pkg::HALF32_W;
        w9        = sfuc_pkg::WR_W'(wround >>> 32);
        u9        = sfuc_pkg::WR_W'(u8_reg);
        v9        = sfuc_pkg::WR_W'(v8_reg);
        pass_next = (u9 >= sfuc_pkg::WR_W'(cfg_reg[sfuc_pkg::REG_U_MIN]))
                 && (u9 <= sfuc_pkg::WR_W'(cfg_reg[sfuc_pkg::REG_U_MAX]))
                 && (v9 <= sfuc_pkg::WR_W'(cfg_reg[sfuc_pkg::REG_V_MAX]))
                 && (w9 <= sfuc_pkg::WR_W'(cfg_reg[sfuc_pkg::REG_W_MAX]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= s_tdata[16:0];
            y1_reg   <= s_tdata[33:17];
            z1_reg   <= s_tdata[50:34];

            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            xsq2_reg <= x1_reg * x1_reg;
            ysq2_reg <= y1_reg * y1_reg;
            px2_reg  <= x1_reg * sfuc_pkg::C_CYX_HALF;
            py2_reg  <= y1_reg * sfuc_pkg::C_CYY;
            pz2_reg  <= z1_reg * sfuc_pkg::C_SIN_THE;
            ps2_reg  <= x1_reg * sfuc_pkg::C_SIN_PHI;

            sec3_reg <= sec3_next;
            y3_reg   <= y2_reg;
            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;
            pz3_reg  <= pz2_reg;
            ps3_reg  <= ps2_reg;

            sec4_reg <= sec3_reg;
            yi4_reg  <= yi4_next;
            xi4_reg  <= xi4_next;

            sec5_reg <= sec4_reg;
            a5_reg   <= sfuc_pkg::A_W'(yi4_reg) - sfuc_pkg::YLO_S;
            b5_reg   <= sfuc_pkg::PLANE_S - sfuc_pkg::A_W'(yi4_reg);
            xs5_reg  <= sfuc_pkg::P_W'(xi4_reg) <<< 16;

            sec6_reg <= sec5_reg;
            up6_reg  <= a5_reg * sfuc_pkg::C_RSIN;
            p6_reg   <= b5_reg * sfuc_pkg::C_RTG;
            xs6_reg  <= xs5_reg;

            sec7_reg <= sec6_reg;
            u7_reg   <= sfuc_pkg::R_W'(usum >>> 32);
            v7_reg   <= sfuc_pkg::R_W'(vsum >>> 32);
            w7_reg   <= sfuc_pkg::W16_W'(wsum >>> 16);

            sec8_reg <= sec7_reg;
            u8_reg   <= u7_reg;
            v8_reg   <= v7_reg;
            wp8_reg  <= w7_reg * sfuc_pkg::C_RCOS2;

            sec9_reg    <= sec8_reg;
            inside9_reg <= pass_next;
            u9_reg      <= sfuc_pkg::sat_out(u9);
            v9_reg      <= sfuc_pkg::sat_out(v9);
            w9_reg      <= sfuc_pkg::sat_out(w9);
        end
    end

endmodule

/* verif/tb_sector_fiducial_uvw_cut.sv */
// Testbench for sector_fiducial_uvw_cut: stream hits in, u/v/w cut results checked in order.
`timescale 1ns / 1ps

module tb_sector_fiducial_uvw_cut;

    typedef struct packed {
        logic [sfuc_pkg::IN_W-1:0] z;
        logic [sfuc_pkg::IN_W-1:0] y;
        logic [sfuc_pkg::IN_W-1:0] x;
    } hit_t;

    typedef struct packed {
        logic                       inside_res;
        logic [sfuc_pkg::SEC_W-1:0] sector;
        logic [sfuc_pkg::OUT_W-1:0] coord_u;
        logic [sfuc_pkg::OUT_W-1:0] coord_v;
        logic [sfuc_pkg::OUT_W-1:0] coord_w;
    } cut_t;

    class cut_tracker;
        localparam longint TILT_SIN = 27697;
        localparam longint Y_LOW    = -11991384;
        localparam longint Y_HIGH   = 12448956;
        localparam longint INV_SIN  = 73626;
        localparam longint INV_TAN  = 33552;
        localparam longint INV_COS2 = 71905;
        localparam longint SAT_HI   = (longint'(1) <<< (sfuc_pkg::OUT_W - 1)) - 1;
        localparam longint SAT_LO   = -(longint'(1) <<< (sfuc_pkg::OUT_W - 1));

        cut_t   pending_cuts[$];
        longint lim_u_min, lim_u_max, lim_v_max, lim_w_max;
        longint rot_cos[6], rot_sin[6], tilt_x[6], tilt_y[6];
        int     fails;

        function new();
            rot_cos = '{65536, 32768, -32768, -65536, -32768, 32768};
            rot_sin = '{0, 56756, 56756, 0, -56756, -56756};
            tilt_x  = '{59396, 29698, -29698, -59396, -29698, 29698};
            tilt_y  = '{0, 51438, 51438, 0, -51438, -51438};
            lim_u_min = 4480;
            lim_u_max = 25920;
            lim_v_max = 23168;
            lim_w_max = 25280;
            fails = 0;
        endfunction

        function void set_limit(logic [1:0] idx, logic signed [sfuc_pkg::CFG_W-1:0] val);
            case (idx)
                sfuc_pkg::REG_U_MIN: lim_u_min = val;
                sfuc_pkg::REG_U_MAX: lim_u_max = val;
                sfuc_pkg::REG_V_MAX: lim_v_max = val;
                sfuc_pkg::REG_W_MAX: lim_w_max = val;
                default: ;
            endcase
        endfunction

        // floor(v / 2^n + 1/2)
        function longint round_shift(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function longint clip(longint v);
            if (v > SAT_HI)
                return SAT_HI;
            if (v < SAT_LO)
                return SAT_LO;
            return v;
        endfunction

        function logic [sfuc_pkg::SEC_W-1:0] sector_of(longint x, longint y);
            longint xx;
            longint yy3;
            xx = x * x;
            yy3 = 3 * y * y;
            if (y == 0)
                return (x < 0) ? sfuc_pkg::SECTOR_3 : sfuc_pkg::SECTOR_0;
            if (y > 0)
            begin
                if (x > 0)
                    return (yy3 > xx) ? sfuc_pkg::SECTOR_1 : sfuc_pkg::SECTOR_0;
                if (x == 0)
                    return sfuc_pkg::SECTOR_2;
                return (xx > yy3) ? sfuc_pkg::SECTOR_3 : sfuc_pkg::SECTOR_2;
            end
            if (x < 0)
                return (yy3 > xx) ? sfuc_pkg::SECTOR_4 : sfuc_pkg::SECTOR_3;
            if (x == 0)
                return sfuc_pkg::SECTOR_5;
            return (xx > yy3) ? sfuc_pkg::SECTOR_0 : sfuc_pkg::SECTOR_5;
        endfunction

        function cut_t cut_from_hit(hit_t h);
            longint x, y, z, yi, xi, ylo, yhi, plane, u, v, w;
            int     s;
            cut_t   r;
            x = longint'($signed(h.x));
            y = longint'($signed(h.y));
            z = longint'($signed(h.z));
            r.sector = sector_of(x, y);
            s = int'(r.sector);
            ylo = Y_LOW * (longint'(1) <<< sfuc_pkg::COORD_FRAC_BITS);
            yhi = Y_HIGH * (longint'(1) <<< sfuc_pkg::COORD_FRAC_BITS);
            yi = x * tilt_x[s] + y * tilt_y[s] - z * TILT_SIN;
            xi = y * rot_cos[s] - x * rot_sin[s];
            u = round_shift((yi - ylo) * INV_SIN, 32);
            plane = (2 * yhi - ylo - yi) * INV_TAN;
            v = round_shift(plane - xi * 65536, 32);
            w = round_shift(round_shift(plane + xi * 65536, 16) * INV_COS2, 32);
            // cut decided on unsaturated coordinates
            r.inside_res = (u >= lim_u_min) && (u <= lim_u_max) && (v <= lim_v_max)
                           && (w <= lim_w_max);
            r.coord_u = sfuc_pkg::OUT_W'(clip(u));
            r.coord_v = sfuc_pkg::OUT_W'(clip(v));
            r.coord_w = sfuc_pkg::OUT_W'(clip(w));
            return r;
        endfunction

        function void note_hit(hit_t h);
            pending_cuts.push_back(cut_from_hit(h));
        endfunction

        task report(string msg);
            if (fails < 100)
                $display("%0t mismatch: %s", $time, msg);
            fails++;
        endtask

        task check_cut(cut_t got);
            cut_t want;
            if (pending_cuts.size() == 0)
            begin
                report($sformatf("result with nothing pending, sector %0d", got.sector));
                return;
            end
            want = pending_cuts.pop_front();
            if (got.inside_res !== want.inside_res)
                report($sformatf("inside_res got %b want %b", got.inside_res, want.inside_res));
            if (got.sector !== want.sector)
                report($sformatf("sector got %0d want %0d", got.sector, want.sector));
            if (got.coord_u !== want.coord_u)
                report($sformatf("coord_u got %0d want %0d",
                                 $signed(got.coord_u), $signed(want.coord_u)));
            if (got.coord_v !== want.coord_v)
                report($sformatf("coord_v got %0d want %0d",
                                 $signed(got.coord_v), $signed(want.coord_v)));
            if (got.coord_w !== want.coord_w)
                report($sformatf("coord_w got %0d want %0d",
                                 $signed(got.coord_w), $signed(want.coord_w)));
        endtask
    endclass

    localparam int DRAIN_CYCLES = 16;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [55:0]       s_tdata = '0;  // hit_x[16:0], hit_y[33:17], hit_z[50:34], zero pad
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [55:0]       m_tdata;       // coord_u[17:0], coord_v[35:18], coord_w[53:36], zero pad
    logic [3:0]        m_tuser;       // inside_res[0], sector[3:1]
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [sfuc_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    int         src_idle_pct = 37;
    int         sink_stall_pct = 76;
    cut_tracker tracker = new();

    sector_fiducial_uvw_cut dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic hit_t mk_hit(int x, int y, int z);
        hit_t h;
        h.x = sfuc_pkg::IN_W'(x);
        h.y = sfuc_pkg::IN_W'(y);
        h.z = sfuc_pkg::IN_W'(z);
        return h;
    endfunction

    function automatic hit_t random_hit();
        hit_t h;
        int   pick;
        pick = $urandom_range(9);
        if (pick < 6)
        begin
            // detector-like positions, mixed pass and fail under typical limits
            h = mk_hit(int'($urandom_range(60000)) - 30000, int'($urandom_range(60000)) - 30000,
                       int'($urandom_range(40000)) - 5000);
        end
        else if (pick < 9)
        begin
            h.x = sfuc_pkg::IN_W'($urandom);
            h.y = sfuc_pkg::IN_W'($urandom);
            h.z = sfuc_pkg::IN_W'($urandom);
        end
        else
        begin
            h.x = sfuc_pkg::IN_W'($urandom);
            h.y = sfuc_pkg::IN_W'($urandom);
            h.z = sfuc_pkg::IN_W'($urandom);
            if ($urandom_range(1))
                h.x = '0;
            else
                h.y = '0;
        end
        return h;
    endfunction

    function automatic logic signed [sfuc_pkg::CFG_W-1:0] random_limit(int lo, int hi);
        return sfuc_pkg::CFG_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    task automatic send_hit(input hit_t h);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, h};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_hit(h);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_hit(random_hit());
        s_tvalid <= 1'b0;
    endtask

    task automatic write_limits(input logic signed [sfuc_pkg::CFG_W-1:0] umin, umax, vmax, wmax);
        logic signed [sfuc_pkg::CFG_W-1:0] vals[4];
        logic [1:0]                        idx[4];
        vals = '{umin, umax, vmax, wmax};
        idx = '{sfuc_pkg::REG_U_MIN, sfuc_pkg::REG_U_MAX, sfuc_pkg::REG_V_MAX,
                sfuc_pkg::REG_W_MAX};
        for (int i = 0; i < 4; i++)
        begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idx[i], 2'b00};
            pwdata <= {{(32 - sfuc_pkg::CFG_W){vals[i][sfuc_pkg::CFG_W-1]}}, vals[i]};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            tracker.set_limit(idx[i], vals[i]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_random_limits();
        logic signed [sfuc_pkg::CFG_W-1:0] umin;
        umin = random_limit(-20000, 20000);
        write_limits(umin, sfuc_pkg::CFG_W'($signed(umin) + int'($urandom_range(40000))),
                     random_limit(-10000, 40000), random_limit(-10000, 40000));
    endtask

    task automatic drain();
        while (tracker.pending_cuts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // result side
    initial
    begin
        cut_t got;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.inside_res = m_tuser[0];
                got.sector = m_tuser[3:1];
                got.coord_u = m_tdata[17:0];
                got.coord_v = m_tdata[35:18];
                got.coord_w = m_tdata[53:36];
                tracker.check_cut(got);
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: origin, axes, field extremes, both sides of the 30-degree lines
        send_hit(mk_hit(0, 0, 0));
        send_hit(mk_hit(0, 0, -65536));
        send_hit(mk_hit(65535, 0, 0));
        send_hit(mk_hit(-65536, 0, 65535));
        send_hit(mk_hit(-1, 0, 100));
        send_hit(mk_hit(0, 65535, 0));
        send_hit(mk_hit(0, -65536, 0));
        send_hit(mk_hit(-65536, -65536, -65536));
        send_hit(mk_hit(65535, 65535, 65535));
        send_hit(mk_hit(65535, -65536, 65535));
        send_hit(mk_hit(-65536, 65535, -65536));
        send_hit(mk_hit(56756, 32768, 1000));
        send_hit(mk_hit(56755, 32768, 1000));
        send_hit(mk_hit(-56756, 32768, 1000));
        send_hit(mk_hit(-56755, 32768, 1000));
        send_hit(mk_hit(-56756, -32768, 1000));
        send_hit(mk_hit(-56755, -32768, 1000));
        send_hit(mk_hit(56756, -32768, 1000));
        send_hit(mk_hit(56755, -32768, 1000));
        send_hit(mk_hit(10000, 0, 10000));
        send_hit(mk_hit(-5000, 9000, 12000));
        send_hit(mk_hit(-5000, -9000, 12000));
        send_hit(mk_hit(1, -1, -1));
        s_tvalid <= 1'b0;
        drain();

        write_limits(-sfuc_pkg::CFG_W'(131072), sfuc_pkg::CFG_W'(131071),
                     sfuc_pkg::CFG_W'(131071), sfuc_pkg::CFG_W'(131071));
        send_random(180);
        drain();

        src_idle_pct = 76;
        sink_stall_pct = 37;
        write_limits(sfuc_pkg::CFG_W'(131071), -sfuc_pkg::CFG_W'(131072),
                     -sfuc_pkg::CFG_W'(131072), -sfuc_pkg::CFG_W'(131072));
        send_random(90);
        drain();
        write_random_limits();
        send_random(90);
        drain();

        src_idle_pct = 0;
        sink_stall_pct = 0;
        write_random_limits();
        send_random(90);
        drain();
        write_limits(sfuc_pkg::CFG_W'(4480), sfuc_pkg::CFG_W'(25920),
                     sfuc_pkg::CFG_W'(23168), sfuc_pkg::CFG_W'(25280));
        send_random(100);
        drain();

        if (tracker.fails == 0 && tracker.pending_cuts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* sector_fiducial_uvw_cut.f */
src/sfuc_pkg.sv
src/sector_fiducial_uvw_cut.sv
verif/tb_sector_fiducial_uvw_cut.sv
